// ===== hdl/fdcr_pkg.sv =====
// fdcr_pkg: shared types and constants of the floppy controller register front end
// holds transaction payload structs, operation codes, address map and status codes
// no dependencies
`default_nettype none

package fdcr_pkg;

   localparam int OP_W      = 4;
   localparam int ADDR_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int NMI_W     = 2;
   localparam int DREQ_W    = 3;
   localparam int SEL_W     = 3;
   localparam int DIR_W     = 2;
   localparam int NIBBLE_W  = 4;

   // transaction operations
   localparam logic [OP_W-1:0] OP_BUS_WRITE  = 4'd0;
   localparam logic [OP_W-1:0] OP_BUS_READ   = 4'd1;
   localparam logic [OP_W-1:0] OP_DISC_BYTE  = 4'd2;
   localparam logic [OP_W-1:0] OP_COMPLETE   = 4'd3;
   localparam logic [OP_W-1:0] OP_NOT_FOUND  = 4'd4;
   localparam logic [OP_W-1:0] OP_DATA_CRC   = 4'd5;
   localparam logic [OP_W-1:0] OP_HEADER_CRC = 4'd6;
   localparam logic [OP_W-1:0] OP_PROTECT    = 4'd7;
   localparam logic [OP_W-1:0] OP_BYTE_REQ   = 4'd8;

   // bus address map, both variants
   localparam logic [ADDR_W-1:0] ADDR_CTRL_A  = 16'hFE80;
   localparam logic [ADDR_W-1:0] ADDR_CTRL_B  = 16'hFE24;
   localparam logic [ADDR_W-1:0] ADDR_CMD_A   = 16'hFE84;
   localparam logic [ADDR_W-1:0] ADDR_CMD_B   = 16'hFE28;
   localparam logic [ADDR_W-1:0] ADDR_TRK_A   = 16'hFE85;
   localparam logic [ADDR_W-1:0] ADDR_TRK_B   = 16'hFE29;
   localparam logic [ADDR_W-1:0] ADDR_SEC_A   = 16'hFE86;
   localparam logic [ADDR_W-1:0] ADDR_SEC_B   = 16'hFE2A;
   localparam logic [ADDR_W-1:0] ADDR_DATA_A  = 16'hFE87;
   localparam logic [ADDR_W-1:0] ADDR_DATA_B  = 16'hFE2B;

   // decoded register selects
   localparam logic [SEL_W-1:0] SEL_NONE   = 3'd0;
   localparam logic [SEL_W-1:0] SEL_CTRL_A = 3'd1;
   localparam logic [SEL_W-1:0] SEL_CTRL_B = 3'd2;
   localparam logic [SEL_W-1:0] SEL_CMD    = 3'd3;
   localparam logic [SEL_W-1:0] SEL_TRK    = 3'd4;
   localparam logic [SEL_W-1:0] SEL_SEC    = 3'd5;
   localparam logic [SEL_W-1:0] SEL_DATA   = 3'd6;

   // command high nibbles
   localparam logic [NIBBLE_W-1:0] CMD_RESTORE      = 4'h0;
   localparam logic [NIBBLE_W-1:0] CMD_SEEK         = 4'h1;
   localparam logic [NIBBLE_W-1:0] CMD_STEP         = 4'h2;
   localparam logic [NIBBLE_W-1:0] CMD_STEP_U       = 4'h3;
   localparam logic [NIBBLE_W-1:0] CMD_STEP_IN      = 4'h4;
   localparam logic [NIBBLE_W-1:0] CMD_STEP_IN_U    = 4'h5;
   localparam logic [NIBBLE_W-1:0] CMD_STEP_OUT     = 4'h6;
   localparam logic [NIBBLE_W-1:0] CMD_STEP_OUT_U   = 4'h7;
   localparam logic [NIBBLE_W-1:0] CMD_READ_SECTOR  = 4'h8;
   localparam logic [NIBBLE_W-1:0] CMD_WRITE_SECTOR = 4'hA;
   localparam logic [NIBBLE_W-1:0] CMD_READ_ADDR    = 4'hC;
   localparam logic [NIBBLE_W-1:0] CMD_FORCE_INT    = 4'hD;
   localparam logic [NIBBLE_W-1:0] CMD_WRITE_TRACK  = 4'hF;

   // disc request codes
   localparam logic [DREQ_W-1:0] DREQ_NONE        = 3'd0;
   localparam logic [DREQ_W-1:0] DREQ_SEEK        = 3'd1;
   localparam logic [DREQ_W-1:0] DREQ_READ_SECTOR = 3'd2;
   localparam logic [DREQ_W-1:0] DREQ_WRITE_SECTOR= 3'd3;
   localparam logic [DREQ_W-1:0] DREQ_READ_ADDR   = 3'd4;
   localparam logic [DREQ_W-1:0] DREQ_FORMAT      = 3'd5;

   // step direction codes
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_IN   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_OUT  = 2'd2;

   // status values and bits
   localparam logic [BYTE_W-1:0] STATUS_MOTOR     = 8'h80;
   localparam logic [BYTE_W-1:0] STATUS_TYPE1     = 8'h80 | 8'h21;
   localparam logic [BYTE_W-1:0] STATUS_XFER      = 8'h81;
   localparam logic [BYTE_W-1:0] STATUS_WRITE     = 8'h83;
   localparam logic [BYTE_W-1:0] STATUS_TRACK0    = 8'h04;
   localparam logic [BYTE_W-1:0] STATUS_DRQ       = 8'h02;
   localparam logic [BYTE_W-1:0] FAULT_NOT_FOUND  = 8'h90;
   localparam logic [BYTE_W-1:0] FAULT_DATA_CRC   = 8'h88;
   localparam logic [BYTE_W-1:0] FAULT_HEADER_CRC = 8'h98;
   localparam logic [BYTE_W-1:0] FAULT_PROTECT    = 8'hC0;
   localparam logic [BYTE_W-1:0] READ_UNMAPPED    = 8'hFE;
   localparam logic [BYTE_W-1:0] TRACK_MAX        = 8'hFF;

   // interrupt flag bits
   localparam logic [NMI_W-1:0] IRQ_CMD  = 2'b01;
   localparam logic [NMI_W-1:0] IRQ_DATA = 2'b10;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] write_data;
      logic              last_flag;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic [NMI_W-1:0]  nmi_flags;
      logic [DREQ_W-1:0] disc_request;
      logic              request_drive;
      logic [BYTE_W-1:0] request_track;
      logic [BYTE_W-1:0] request_sector;
      logic              request_side;
      logic              request_density;
      logic              byte_present;
      logic              motor_on;
      logic              spindown_arm;
      logic              callback_timer_action;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/fdcr_if.sv =====
// fdcr_if: valid/ready channel interfaces for requests and responses
// depends on fdcr_pkg for field widths
`default_nettype none

interface fdcr_req_if;
   import fdcr_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address;
   logic [BYTE_W-1:0] write_data;
   logic              last_flag;

   modport source (output valid, output operation, output address, output write_data,
                   output last_flag, input ready);
   modport sink (input valid, input operation, input address, input write_data,
                 input last_flag, output ready);
endinterface

interface fdcr_rsp_if;
   import fdcr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic [NMI_W-1:0]  nmi_flags;
   logic [DREQ_W-1:0] disc_request;
   logic              request_drive;
   logic [BYTE_W-1:0] request_track;
   logic [BYTE_W-1:0] request_sector;
   logic              request_side;
   logic              request_density;
   logic              byte_present;
   logic              motor_on;
   logic              spindown_arm;
   logic              callback_timer_action;

   modport source (output valid, output read_data, output nmi_flags, output disc_request,
                   output request_drive, output request_track, output request_sector,
                   output request_side, output request_density, output byte_present,
                   output motor_on, output spindown_arm, output callback_timer_action,
                   input ready);
   modport sink (input valid, input read_data, input nmi_flags, input disc_request,
                 input request_drive, input request_track, input request_sector,
                 input request_side, input request_density, input byte_present,
                 input motor_on, input spindown_arm, input callback_timer_action,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/fdcr_addr_decode.sv =====
// fdcr_addr_decode: maps a bus address onto a register select, both address maps
// depends on fdcr_pkg
`default_nettype none

module fdcr_addr_decode (
   input  wire logic [fdcr_pkg::ADDR_W-1:0] address,
   output logic      [fdcr_pkg::SEL_W-1:0]  reg_sel
);
   import fdcr_pkg::*;

   always_comb begin
      case (address)
         ADDR_CTRL_A:              reg_sel = SEL_CTRL_A;
         ADDR_CTRL_B:              reg_sel = SEL_CTRL_B;
         ADDR_CMD_A,  ADDR_CMD_B:  reg_sel = SEL_CMD;
         ADDR_TRK_A,  ADDR_TRK_B:  reg_sel = SEL_TRK;
         ADDR_SEC_A,  ADDR_SEC_B:  reg_sel = SEL_SEC;
         ADDR_DATA_A, ADDR_DATA_B: reg_sel = SEL_DATA;
         default:                  reg_sel = SEL_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/fdcr_engine.sv =====
// fdcr_engine: controller register file and the per-transaction update logic
// depends on fdcr_pkg; register select comes from fdcr_addr_decode
`default_nettype none

module fdcr_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire fdcr_pkg::req_type          item,
   input  wire logic [fdcr_pkg::SEL_W-1:0] reg_sel,
   output fdcr_pkg::rsp_type               result
);
   import fdcr_pkg::*;

   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] track_ff,   track_in;
   logic [BYTE_W-1:0] sector_ff,  sector_in;
   logic [BYTE_W-1:0] data_ff,    data_in;
   logic [BYTE_W-1:0] status_ff,  status_in;
   logic [BYTE_W-1:0] head_ff,    head_in;
   logic [DIR_W-1:0]  dir_ff,     dir_in;
   logic              drive_ff,   drive_in;
   logic              side_ff,    side_in;
   logic              dens_ff,    dens_in;
   logic              bytew_ff,   bytew_in;
   logic [NMI_W-1:0]  irq_ff,     irq_in;
   logic              motor_ff,   motor_in;

   logic [BYTE_W-1:0]   at_zero;
   logic [BYTE_W-1:0]   head_up;
   logic [BYTE_W-1:0]   head_down;
   logic [BYTE_W-1:0]   head_step;
   logic [NIBBLE_W-1:0] wr_cmd;
   logic [NIBBLE_W-1:0] cur_cmd;
   logic [BYTE_W-1:0]   rd;
   logic                present;
   logic [DREQ_W-1:0]   o_req;
   logic [BYTE_W-1:0]   o_trk;
   logic [BYTE_W-1:0]   o_sec;
   logic                o_side;
   logic                o_dens;
   logic                o_arm;
   logic                o_cancel;

   // track zero is sampled before any step of the same command
   assign at_zero   = (head_ff == '0) ? STATUS_TRACK0 : '0;
   assign head_up   = (head_ff != TRACK_MAX) ? head_ff + 8'd1 : head_ff;
   assign head_down = (head_ff != '0) ? head_ff - 8'd1 : head_ff;
   assign wr_cmd    = item.write_data[7:4];
   assign cur_cmd   = command_ff[7:4];

   always_comb begin
      case (dir_ff)
         DIR_IN:  head_step = head_up;
         DIR_OUT: head_step = head_down;
         default: head_step = head_ff;
      endcase
   end

   always_comb begin
      command_in = command_ff;
      track_in   = track_ff;
      sector_in  = sector_ff;
      data_in    = data_ff;
      status_in  = status_ff;
      head_in    = head_ff;
      dir_in     = dir_ff;
      drive_in   = drive_ff;
      side_in    = side_ff;
      dens_in    = dens_ff;
      bytew_in   = bytew_ff;
      irq_in     = irq_ff;
      motor_in   = motor_ff;
      rd         = '0;
      present    = 1'b0;
      o_req      = DREQ_NONE;
      o_trk      = '0;
      o_sec      = '0;
      o_side     = 1'b0;
      o_dens     = 1'b0;
      o_arm      = 1'b0;
      o_cancel   = 1'b0;

      case (item.operation)
         OP_BUS_WRITE: begin
            case (reg_sel)
               SEL_CTRL_A: begin
                  drive_in = item.write_data[1];
                  side_in  = item.write_data[2];
                  dens_in  = ~item.write_data[3];
               end
               SEL_CTRL_B: begin
                  drive_in = item.write_data[1];
                  side_in  = item.write_data[4];
                  dens_in  = ~item.write_data[5];
               end
               SEL_CMD: begin
                  // busy rejects everything except force interrupt
                  if (!(status_ff[0] && wr_cmd != CMD_FORCE_INT)) begin
                     command_in = item.write_data;
                     motor_in   = 1'b1;
                     case (wr_cmd) inside
                        CMD_RESTORE: begin
                           status_in = STATUS_TYPE1 | at_zero;
                           o_req     = DREQ_SEEK;
                           o_trk     = '0;
                        end
                        CMD_SEEK: begin
                           status_in = STATUS_TYPE1 | at_zero;
                           o_req     = DREQ_SEEK;
                           o_trk     = data_ff;
                        end
                        CMD_STEP, CMD_STEP_U: begin
                           status_in = STATUS_TYPE1 | at_zero;
                           head_in   = head_step;
                           o_req     = DREQ_SEEK;
                           o_trk     = head_step;
                        end
                        CMD_STEP_IN, CMD_STEP_IN_U: begin
                           status_in = STATUS_TYPE1 | at_zero;
                           head_in   = head_up;
                           dir_in    = DIR_IN;
                           o_req     = DREQ_SEEK;
                           o_trk     = head_up;
                        end
                        CMD_STEP_OUT, CMD_STEP_OUT_U: begin
                           status_in = STATUS_TYPE1 | at_zero;
                           head_in   = head_down;
                           dir_in    = DIR_OUT;
                           o_req     = DREQ_SEEK;
                           o_trk     = head_down;
                        end
                        CMD_READ_SECTOR: begin
                           status_in = STATUS_XFER;
                           o_req     = DREQ_READ_SECTOR;
                           o_trk     = track_ff;
                           o_sec     = sector_ff;
                           o_side    = side_ff;
                           o_dens    = dens_ff;
                        end
                        CMD_WRITE_SECTOR: begin
                           status_in = STATUS_WRITE;
                           irq_in    = irq_ff | IRQ_DATA;
                           o_req     = DREQ_WRITE_SECTOR;
                           o_trk     = track_ff;
                           o_sec     = sector_ff;
                           o_side    = side_ff;
                           o_dens    = dens_ff;
                        end
                        CMD_READ_ADDR: begin
                           status_in = STATUS_XFER;
                           o_req     = DREQ_READ_ADDR;
                           o_trk     = track_ff;
                           o_side    = side_ff;
                           o_dens    = dens_ff;
                        end
                        CMD_FORCE_INT: begin
                           // motor stop clears the motor bit again
                           o_cancel  = 1'b1;
                           status_in = at_zero;
                           irq_in    = item.write_data[3] ? IRQ_CMD : '0;
                           motor_in  = 1'b0;
                        end
                        CMD_WRITE_TRACK: begin
                           status_in = STATUS_XFER;
                           o_req     = DREQ_FORMAT;
                           o_trk     = track_ff;
                           o_side    = side_ff;
                           o_dens    = dens_ff;
                        end
                        default: begin
                           // undefined commands behave as record not found
                           o_cancel  = 1'b1;
                           irq_in    = IRQ_CMD;
                           status_in = FAULT_NOT_FOUND & ~STATUS_MOTOR;
                           motor_in  = 1'b0;
                        end
                     endcase
                  end
               end
               SEL_TRK: track_in  = item.write_data;
               SEL_SEC: sector_in = item.write_data;
               SEL_DATA: begin
                  irq_in    = irq_ff & IRQ_CMD;
                  status_in = status_ff & ~STATUS_DRQ;
                  data_in   = item.write_data;
                  bytew_in  = 1'b1;
               end
               default: ;
            endcase
         end
         OP_BUS_READ: begin
            case (reg_sel)
               SEL_CMD: begin
                  irq_in = irq_ff & IRQ_DATA;
                  rd     = status_ff;
               end
               SEL_TRK: rd = track_ff;
               SEL_SEC: rd = sector_ff;
               SEL_DATA: begin
                  irq_in    = irq_ff & IRQ_CMD;
                  status_in = status_ff & ~STATUS_DRQ;
                  rd        = data_ff;
               end
               default: rd = READ_UNMAPPED;
            endcase
         end
         OP_DISC_BYTE: begin
            data_in   = item.write_data;
            status_in = status_ff | STATUS_DRQ;
            irq_in    = irq_ff | IRQ_DATA;
         end
         OP_COMPLETE: begin
            case (cur_cmd) inside
               CMD_RESTORE: begin
                  head_in   = '0;
                  track_in  = '0;
                  status_in = STATUS_MOTOR;
                  o_arm     = 1'b1;
                  irq_in    = irq_ff | IRQ_CMD;
               end
               CMD_SEEK: begin
                  // track zero here follows the new head position
                  head_in   = data_ff;
                  track_in  = data_ff;
                  status_in = STATUS_MOTOR | ((data_ff == '0) ? STATUS_TRACK0 : '0);
                  o_arm     = 1'b1;
                  irq_in    = irq_ff | IRQ_CMD;
               end
               [CMD_STEP:CMD_STEP_OUT_U]: begin
                  if (cur_cmd[0]) begin
                     track_in = head_ff;
                  end
                  status_in = STATUS_MOTOR | at_zero;
                  o_arm     = 1'b1;
                  irq_in    = irq_ff | IRQ_CMD;
               end
               CMD_READ_SECTOR, CMD_WRITE_SECTOR, CMD_WRITE_TRACK: begin
                  status_in = STATUS_MOTOR;
                  o_arm     = 1'b1;
                  irq_in    = irq_ff | IRQ_CMD;
               end
               CMD_READ_ADDR: begin
                  status_in = STATUS_MOTOR;
                  sector_in = track_ff;
                  o_arm     = 1'b1;
                  irq_in    = irq_ff | IRQ_CMD;
               end
               default: ;
            endcase
         end
         OP_NOT_FOUND, OP_DATA_CRC, OP_HEADER_CRC, OP_PROTECT: begin
            o_cancel = 1'b1;
            irq_in   = IRQ_CMD;
            motor_in = 1'b0;
            case (item.operation)
               OP_NOT_FOUND:  status_in = FAULT_NOT_FOUND & ~STATUS_MOTOR;
               OP_DATA_CRC:   status_in = FAULT_DATA_CRC & ~STATUS_MOTOR;
               OP_HEADER_CRC: status_in = FAULT_HEADER_CRC & ~STATUS_MOTOR;
               default:       status_in = FAULT_PROTECT & ~STATUS_MOTOR;
            endcase
         end
         OP_BYTE_REQ: begin
            if (bytew_ff) begin
               if (!item.last_flag) begin
                  irq_in    = irq_ff | IRQ_DATA;
                  status_in = status_ff | STATUS_DRQ;
               end
               bytew_in = 1'b0;
               rd       = data_ff;
               present  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.read_data             = rd;
      result.nmi_flags             = irq_in;
      result.disc_request          = o_req;
      result.request_drive         = (o_req != DREQ_NONE) ? drive_ff : 1'b0;
      result.request_track         = o_trk;
      result.request_sector        = o_sec;
      result.request_side          = o_side;
      result.request_density       = o_dens;
      result.byte_present          = present;
      result.motor_on              = motor_in;
      result.spindown_arm          = o_arm;
      result.callback_timer_action = o_cancel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         track_ff   <= '0;
         sector_ff  <= '0;
         data_ff    <= '0;
         status_ff  <= '0;
         head_ff    <= '0;
         dir_ff     <= DIR_NONE;
         drive_ff   <= 1'b0;
         side_ff    <= 1'b0;
         dens_ff    <= 1'b0;
         bytew_ff   <= 1'b0;
         irq_ff     <= '0;
         motor_ff   <= 1'b0;
      end else if (fire) begin
         command_ff <= command_in;
         track_ff   <= track_in;
         sector_ff  <= sector_in;
         data_ff    <= data_in;
         status_ff  <= status_in;
         head_ff    <= head_in;
         dir_ff     <= dir_in;
         drive_ff   <= drive_in;
         side_ff    <= side_in;
         dens_ff    <= dens_in;
         bytew_ff   <= bytew_in;
         irq_ff     <= irq_in;
         motor_ff   <= motor_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/floppy_controller_registers_top.sv =====
// Floppy controller register front end. Each request transaction is a bus write or read,
// a disc event or a byte request; each yields exactly one response transaction. A request
// is held in an input register, processed against the register file, and its response lands
// in an output register: one transaction per cycle sustained while responses are taken,
// with a request passing the input and then the output register. The rate is set by the
// register file update loop. A waiting response stalls processing; one further request
// can still be taken into the input register, after which the request side stalls.
// depends on fdcr_pkg, fdcr_if, fdcr_addr_decode and fdcr_engine
`default_nettype none

module floppy_controller_registers_top (
   input wire logic clock,
   input wire logic reset,
   fdcr_req_if.sink   req_ch,
   fdcr_rsp_if.source rsp_ch
);
   import fdcr_pkg::*;

   logic              req_valid_ff, req_valid_in;
   req_type           req_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           result;
   logic [SEL_W-1:0]  reg_sel;
   logic              fire;
   logic              req_take;

   // the held request is processed when the output register is free or draining
   assign fire     = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !req_valid_ff || fire;
   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ch.ready);

   fdcr_addr_decode u_decode (
      .address (req_data_ff.address),
      .reg_sel (reg_sel)
   );

   fdcr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (req_data_ff),
      .reg_sel (reg_sel),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff.operation  <= req_ch.operation;
         req_data_ff.address    <= req_ch.address;
         req_data_ff.write_data <= req_ch.write_data;
         req_data_ff.last_flag  <= req_ch.last_flag;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.read_data             = rsp_data_ff.read_data;
   assign rsp_ch.nmi_flags             = rsp_data_ff.nmi_flags;
   assign rsp_ch.disc_request          = rsp_data_ff.disc_request;
   assign rsp_ch.request_drive         = rsp_data_ff.request_drive;
   assign rsp_ch.request_track         = rsp_data_ff.request_track;
   assign rsp_ch.request_sector        = rsp_data_ff.request_sector;
   assign rsp_ch.request_side          = rsp_data_ff.request_side;
   assign rsp_ch.request_density       = rsp_data_ff.request_density;
   assign rsp_ch.byte_present          = rsp_data_ff.byte_present;
   assign rsp_ch.motor_on              = rsp_data_ff.motor_on;
   assign rsp_ch.spindown_arm          = rsp_data_ff.spindown_arm;
   assign rsp_ch.callback_timer_action = rsp_data_ff.callback_timer_action;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for the floppy controller register front end
// drives directed and random transactions, predicts every response in step with the block
// depends on fdcr_pkg, fdcr_if and floppy_controller_registers_top
module tb;
   import fdcr_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int MODE_SPAN    = 60;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdcr_req_if req_ch ();
   fdcr_rsp_if rsp_ch ();

   floppy_controller_registers_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the controller registers
   logic [BYTE_W-1:0] m_cmd, m_track, m_sector, m_data, m_status, m_head;
   logic [DIR_W-1:0]  m_dir;
   logic              m_drive, m_side, m_dd, m_wr_waiting, m_motor;
   logic [NMI_W-1:0]  m_irq;

   rsp_type awaited_rsp [$];
   int      bad_count   = 0;
   int      items_sent  = 0;
   bit      req_gaps_on   = 1'b1;
   bit      rsp_stalls_on = 1'b1;

   function automatic logic [BYTE_W-1:0] head_zero_bit();
      return (m_head == '0) ? STATUS_TRACK0 : '0;
   endfunction

   function automatic void raise_fault(input logic [BYTE_W-1:0] code, inout rsp_type o);
      o.callback_timer_action = 1'b1;
      m_irq    = IRQ_CMD;
      m_status = code & 8'h7F;
      m_motor  = 1'b0;
   endfunction

   function automatic void issue_transfer(input logic [DREQ_W-1:0] kind, input bit with_sector,
                                          inout rsp_type o);
      o.disc_request    = kind;
      o.request_track   = m_track;
      o.request_sector  = with_sector ? m_sector : '0;
      o.request_side    = m_side;
      o.request_density = m_dd;
   endfunction

   // updates the shadow registers for one transaction and returns its response
   function automatic rsp_type step_registers(input req_type r);
      rsp_type                o;
      logic [NIBBLE_W-1:0]    nib;
      logic [BYTE_W-1:0]      v;
      logic [BYTE_W-1:0]      zero_bit;
      bit                     done;
      o = '0;
      v = r.write_data;
      case (r.operation)
         OP_BUS_WRITE: begin
            case (r.address)
               ADDR_CTRL_A: begin
                  m_drive = v[1];
                  m_side  = v[2];
                  m_dd    = ~v[3];
               end
               ADDR_CTRL_B: begin
                  m_drive = v[1];
                  m_side  = v[4];
                  m_dd    = ~v[5];
               end
               ADDR_CMD_A, ADDR_CMD_B: begin
                  nib = v[7:4];
                  zero_bit = head_zero_bit();
                  // busy blocks everything but force interrupt
                  if (!(m_status[0] && nib != CMD_FORCE_INT)) begin
                     m_cmd = v;
                     if (nib != CMD_FORCE_INT) begin
                        m_status = m_status | STATUS_MOTOR;
                        m_motor  = 1'b1;
                     end
                     case (nib)
                        CMD_RESTORE: begin
                           m_status = STATUS_TYPE1 | zero_bit;
                           o.disc_request  = DREQ_SEEK;
                           o.request_track = '0;
                        end
                        CMD_SEEK: begin
                           m_status = STATUS_TYPE1 | zero_bit;
                           o.disc_request  = DREQ_SEEK;
                           o.request_track = m_data;
                        end
                        CMD_STEP, CMD_STEP_U: begin
                           m_status = STATUS_TYPE1 | zero_bit;
                           if (m_dir == DIR_IN && m_head != TRACK_MAX) m_head = m_head + 8'd1;
                           else if (m_dir == DIR_OUT && m_head != '0) m_head = m_head - 8'd1;
                           o.disc_request  = DREQ_SEEK;
                           o.request_track = m_head;
                        end
                        CMD_STEP_IN, CMD_STEP_IN_U: begin
                           m_status = STATUS_TYPE1 | zero_bit;
                           if (m_head != TRACK_MAX) m_head = m_head + 8'd1;
                           o.disc_request  = DREQ_SEEK;
                           o.request_track = m_head;
                           m_dir = DIR_IN;
                        end
                        CMD_STEP_OUT, CMD_STEP_OUT_U: begin
                           m_status = STATUS_TYPE1 | zero_bit;
                           if (m_head != '0) m_head = m_head - 8'd1;
                           o.disc_request  = DREQ_SEEK;
                           o.request_track = m_head;
                           m_dir = DIR_OUT;
                        end
                        CMD_READ_SECTOR: begin
                           m_status = STATUS_XFER;
                           issue_transfer(DREQ_READ_SECTOR, 1'b1, o);
                        end
                        CMD_WRITE_SECTOR: begin
                           m_status = STATUS_WRITE;
                           issue_transfer(DREQ_WRITE_SECTOR, 1'b1, o);
                           m_irq = m_irq | IRQ_DATA;
                        end
                        CMD_READ_ADDR: begin
                           m_status = STATUS_XFER;
                           issue_transfer(DREQ_READ_ADDR, 1'b0, o);
                        end
                        CMD_WRITE_TRACK: begin
                           m_status = STATUS_XFER;
                           issue_transfer(DREQ_FORMAT, 1'b0, o);
                        end
                        CMD_FORCE_INT: begin
                           o.callback_timer_action = 1'b1;
                           m_irq    = v[3] ? IRQ_CMD : '0;
                           m_status = zero_bit;
                           m_motor  = 1'b0;
                        end
                        default: raise_fault(FAULT_NOT_FOUND, o);
                     endcase
                  end
               end
               ADDR_TRK_A, ADDR_TRK_B: m_track = v;
               ADDR_SEC_A, ADDR_SEC_B: m_sector = v;
               ADDR_DATA_A, ADDR_DATA_B: begin
                  m_irq        = m_irq & IRQ_CMD;
                  m_status     = m_status & ~STATUS_DRQ;
                  m_data       = v;
                  m_wr_waiting = 1'b1;
               end
               default: ;
            endcase
         end
         OP_BUS_READ: begin
            case (r.address)
               ADDR_CMD_A, ADDR_CMD_B: begin
                  m_irq       = m_irq & IRQ_DATA;
                  o.read_data = m_status;
               end
               ADDR_TRK_A, ADDR_TRK_B: o.read_data = m_track;
               ADDR_SEC_A, ADDR_SEC_B: o.read_data = m_sector;
               ADDR_DATA_A, ADDR_DATA_B: begin
                  m_irq       = m_irq & IRQ_CMD;
                  m_status    = m_status & ~STATUS_DRQ;
                  o.read_data = m_data;
               end
               default: o.read_data = READ_UNMAPPED;
            endcase
         end
         OP_DISC_BYTE: begin
            m_data   = v;
            m_status = m_status | STATUS_DRQ;
            m_irq    = m_irq | IRQ_DATA;
         end
         OP_COMPLETE: begin
            nib  = m_cmd[7:4];
            done = 1'b1;
            case (nib)
               CMD_RESTORE: begin
                  m_head   = '0;
                  m_track  = '0;
                  m_status = STATUS_MOTOR;
               end
               CMD_SEEK: begin
                  m_head   = m_data;
                  m_track  = m_data;
                  m_status = STATUS_MOTOR | head_zero_bit();
               end
               CMD_STEP, CMD_STEP_U, CMD_STEP_IN, CMD_STEP_IN_U,
               CMD_STEP_OUT, CMD_STEP_OUT_U: begin
                  // the update variants of the step commands copy the head position
                  if (nib[0]) m_track = m_head;
                  m_status = STATUS_MOTOR | head_zero_bit();
               end
               CMD_READ_SECTOR, CMD_WRITE_SECTOR, CMD_WRITE_TRACK: m_status = STATUS_MOTOR;
               CMD_READ_ADDR: begin
                  m_status = STATUS_MOTOR;
                  m_sector = m_track;
               end
               // undefined and force interrupt commands have nothing to complete
               default: done = 1'b0;
            endcase
            if (done) begin
               o.spindown_arm = 1'b1;
               m_irq = m_irq | IRQ_CMD;
            end
         end
         OP_NOT_FOUND:  raise_fault(FAULT_NOT_FOUND, o);
         OP_DATA_CRC:   raise_fault(FAULT_DATA_CRC, o);
         OP_HEADER_CRC: raise_fault(FAULT_HEADER_CRC, o);
         OP_PROTECT:    raise_fault(FAULT_PROTECT, o);
         OP_BYTE_REQ: begin
            if (m_wr_waiting) begin
               if (!r.last_flag) begin
                  m_irq    = m_irq | IRQ_DATA;
                  m_status = m_status | STATUS_DRQ;
               end
               m_wr_waiting   = 1'b0;
               o.read_data    = m_data;
               o.byte_present = 1'b1;
            end
         end
         default: ;
      endcase
      o.nmi_flags     = m_irq;
      o.motor_on      = m_motor;
      o.request_drive = (o.disc_request != DREQ_NONE) ? m_drive : 1'b0;
      return o;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         bad_count++;
      end
   endtask

   // prediction on request accept, comparison on response accept
   always @(posedge clock) begin
      req_type r;
      rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r.operation  = req_ch.operation;
            r.address    = req_ch.address;
            r.write_data = req_ch.write_data;
            r.last_flag  = req_ch.last_flag;
            awaited_rsp.push_back(step_registers(r));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("response transaction with nothing outstanding");
               bad_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("read_data", want.read_data, rsp_ch.read_data);
               check_field("nmi_flags", want.nmi_flags, rsp_ch.nmi_flags);
               check_field("disc_request", want.disc_request, rsp_ch.disc_request);
               check_field("request_drive", want.request_drive, rsp_ch.request_drive);
               check_field("request_track", want.request_track, rsp_ch.request_track);
               check_field("request_sector", want.request_sector, rsp_ch.request_sector);
               check_field("request_side", want.request_side, rsp_ch.request_side);
               check_field("request_density", want.request_density, rsp_ch.request_density);
               check_field("byte_present", want.byte_present, rsp_ch.byte_present);
               check_field("motor_on", want.motor_on, rsp_ch.motor_on);
               check_field("spindown_arm", want.spindown_arm, rsp_ch.spindown_arm);
               check_field("callback_timer_action", want.callback_timer_action,
                           rsp_ch.callback_timer_action);
            end
         end
      end
   end

   // response side back-pressure
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send_event(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data, input logic last);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.address    <= addr;
      req_ch.write_data <= data;
      req_ch.last_flag  <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
      send_event(OP_BUS_WRITE, addr, data, 1'($urandom_range(0, 1)));
   endtask

   task automatic reg_read(input logic [ADDR_W-1:0] addr);
      send_event(OP_BUS_READ, addr, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic disc_event(input logic [OP_W-1:0] op);
      send_event(op, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [ADDR_W-1:0] either(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
      return $urandom_range(0, 1) ? a : b;
   endfunction

   // weighted towards the track limits
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 15))
         0:       return ADDR_CTRL_A;
         1:       return ADDR_CTRL_B;
         2:       return ADDR_CMD_A;
         3:       return ADDR_CMD_B;
         4:       return ADDR_TRK_A;
         5:       return ADDR_TRK_B;
         6:       return ADDR_SEC_A;
         7:       return ADDR_SEC_B;
         8:       return ADDR_DATA_A;
         9:       return ADDR_DATA_B;
         10:      return ADDR_CMD_A + 16'd4;
         11:      return ADDR_CTRL_B - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic finish_command();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) disc_event(OP_COMPLETE);
      else if (pick < 9) disc_event(4'($urandom_range(OP_NOT_FOUND, OP_PROTECT)));
      else reg_write(either(ADDR_CMD_A, ADDR_CMD_B), {CMD_FORCE_INT, 4'($urandom)});
      if ($urandom_range(0, 1)) reg_read(either(ADDR_CMD_A, ADDR_CMD_B));
   endtask

   task automatic run_head_command();
      if ($urandom_range(0, 1)) reg_write(either(ADDR_DATA_A, ADDR_DATA_B), pick_byte());
      reg_write(either(ADDR_CMD_A, ADDR_CMD_B), {4'($urandom_range(0, 7)), 4'($urandom)});
      // an occasional second command lands while busy
      if ($urandom_range(0, 4) == 0) reg_write(either(ADDR_CMD_A, ADDR_CMD_B), 8'($urandom));
      finish_command();
   endtask

   task automatic run_data_command();
      logic [NIBBLE_W-1:0] kind;
      int                  beats;
      case ($urandom_range(0, 3))
         0:       kind = CMD_READ_SECTOR;
         1:       kind = CMD_WRITE_SECTOR;
         2:       kind = CMD_READ_ADDR;
         default: kind = CMD_WRITE_TRACK;
      endcase
      if ($urandom_range(0, 1)) reg_write(either(ADDR_TRK_A, ADDR_TRK_B), pick_byte());
      if ($urandom_range(0, 1)) reg_write(either(ADDR_SEC_A, ADDR_SEC_B), pick_byte());
      if ($urandom_range(0, 2) == 0) reg_write(either(ADDR_CTRL_A, ADDR_CTRL_B), 8'($urandom));
      reg_write(either(ADDR_CMD_A, ADDR_CMD_B), {kind, 4'($urandom)});
      beats = $urandom_range(0, 5);
      repeat (beats) begin
         if (kind == CMD_WRITE_SECTOR || kind == CMD_WRITE_TRACK) begin
            if ($urandom_range(0, 3) != 0) reg_write(either(ADDR_DATA_A, ADDR_DATA_B), 8'($urandom));
            send_event(OP_BYTE_REQ, 16'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0));
         end else begin
            disc_event(OP_DISC_BYTE);
            if ($urandom_range(0, 3) != 0) reg_read(either(ADDR_DATA_A, ADDR_DATA_B));
         end
         if ($urandom_range(0, 7) == 0) reg_read(either(ADDR_CMD_A, ADDR_CMD_B));
      end
      finish_command();
   endtask

   task automatic send_noise();
      logic [OP_W-1:0] op;
      op = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
      send_event(op, pick_address(), 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_register_map();
      reg_read(16'hFFFF);
      reg_write(16'h0000, 8'hFF);
      reg_write(ADDR_CTRL_A, 8'hFF);
      reg_write(ADDR_CTRL_B, 8'h00);
      reg_write(ADDR_SEC_A, 8'hFF);
      reg_write(ADDR_DATA_B, 8'hFF);
      reg_read(ADDR_CMD_A);
   endtask

   task automatic test_head_positioning();
      reg_write(ADDR_CMD_B, {CMD_SEEK, 4'h0});
      reg_write(ADDR_CMD_A, {CMD_READ_SECTOR, 4'h0});
      disc_event(OP_COMPLETE);
      // inward step at the last track stays there
      reg_write(ADDR_CMD_A, {CMD_STEP_IN_U, 4'h0});
      disc_event(OP_COMPLETE);
      reg_write(ADDR_CMD_B, {CMD_RESTORE, 4'h0});
      disc_event(OP_COMPLETE);
      reg_write(ADDR_CMD_A, {CMD_STEP_OUT, 4'h0});
      reg_write(ADDR_CMD_A, {CMD_FORCE_INT, 4'h8});
      disc_event(OP_COMPLETE);
   endtask

   task automatic test_transfer_commands();
      reg_write(ADDR_CMD_A, {CMD_WRITE_SECTOR, 4'h0});
      send_event(OP_BYTE_REQ, 16'h0000, 8'h00, 1'b0);
      send_event(OP_BYTE_REQ, 16'hFFFF, 8'hFF, 1'b1);
      disc_event(OP_COMPLETE);
      reg_write(ADDR_CMD_B, {CMD_READ_ADDR, 4'hF});
      send_event(OP_DISC_BYTE, 16'h0000, 8'h00, 1'b0);
      reg_read(ADDR_DATA_B);
      disc_event(OP_COMPLETE);
      reg_write(ADDR_CMD_A, 8'h9F);
   endtask

   task automatic test_faults_and_unused();
      disc_event(OP_NOT_FOUND);
      disc_event(OP_PROTECT);
      send_event(4'hF, 16'hFFFF, 8'hFF, 1'b1);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int next_switch;
      stop_at     = items_sent + RANDOM_ITEMS;
      next_switch = items_sent;
      while (items_sent < stop_at) begin
         if (items_sent >= next_switch) begin
            case ($urandom_range(0, 3))
               0: begin req_gaps_on = 1'b1; rsp_stalls_on = 1'b1; end
               1: begin req_gaps_on = 1'b0; rsp_stalls_on = 1'b1; end
               2: begin req_gaps_on = 1'b1; rsp_stalls_on = 1'b0; end
               default: begin req_gaps_on = 1'b0; rsp_stalls_on = 1'b0; end
            endcase
            next_switch = items_sent + MODE_SPAN;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: run_head_command();
            3, 4, 5, 6: run_data_command();
            default: repeat ($urandom_range(1, 4)) send_noise();
         endcase
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_BUS_WRITE;
      req_ch.address    = '0;
      req_ch.write_data = '0;
      req_ch.last_flag  = 1'b0;
      m_cmd = '0; m_track = '0; m_sector = '0; m_data = '0; m_status = '0; m_head = '0;
      m_dir = DIR_NONE; m_drive = 1'b0; m_side = 1'b0; m_dd = 1'b0;
      m_wr_waiting = 1'b0; m_irq = '0; m_motor = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_map();
      test_head_positioning();
      test_transfer_commands();
      test_faults_and_unused();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         $error("%0d responses never arrived", awaited_rsp.size());
         bad_count++;
      end
      if (bad_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
